// ===== rtl/astm_record_field_extractor_top_assert.svh =====
// ----------------------------------------------------------------------------
// astm_record_field_extractor_top_assert.svh
// Assertion macros used by the checker file of the record field extractor
// ----------------------------------------------------------------------------
`ifndef ASTM_RECORD_FIELD_EXTRACTOR_TOP_ASSERT_SVH
`define ASTM_RECORD_FIELD_EXTRACTOR_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ASTM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/astm_rfe_pkg.sv =====
// ----------------------------------------------------------------------------
// astm_rfe_pkg
// Types, character codes and the field table of the record field extractor
// ----------------------------------------------------------------------------
package astm_rfe_pkg;

  // framing and separator characters
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // record type letters
  localparam logic [7:0] CH_TYPE_H = 8'h48;
  localparam logic [7:0] CH_TYPE_P = 8'h50;
  localparam logic [7:0] CH_TYPE_O = 8'h4F;
  localparam logic [7:0] CH_TYPE_R = 8'h52;
  localparam logic [7:0] CH_TYPE_L = 8'h4C;

  // field tags
  localparam logic [2:0] TAG_PATIENT = 3'd0;
  localparam logic [2:0] TAG_SAMPLE  = 3'd1;
  localparam logic [2:0] TAG_TEST    = 3'd2;
  localparam logic [2:0] TAG_VALUE   = 3'd3;
  localparam logic [2:0] TAG_UNIT    = 3'd4;
  localparam logic [2:0] TAG_DATE    = 3'd5;
  localparam logic [2:0] TAG_NONE    = 3'd7;

  // max characters streamed per field
  localparam logic [7:0] LIMIT_PATIENT = 8'd199;
  localparam logic [7:0] LIMIT_SHORT   = 8'd9;
  localparam logic [7:0] LIMIT_DATE    = 8'd19;

  localparam logic [7:0] FIELD_MAX = 8'hFF;

  typedef enum logic [2:0] {
    REC_NONE = 3'd0,
    REC_H    = 3'd1,
    REC_P    = 3'd2,
    REC_O    = 3'd3,
    REC_R    = 3'd4,
    REC_L    = 3'd5
  } record_e;

  typedef enum logic [2:0] {
    EXP_H = 3'd0,
    EXP_P = 3'd1,
    EXP_O = 3'd2,
    EXP_R = 3'd3,
    EXP_L = 3'd4
  } expect_e;

  typedef struct packed {
    logic [2:0] tag;
    logic [7:0] limit;
  } field_info_t;

  typedef struct packed {
    logic       event_res;
    logic [2:0] field_tag;
    logic [7:0] char_code;
    logic       record_done;
  } result_t;

  // tag and length limit of a field of a record
  function automatic field_info_t tag_of(record_e rec, logic [7:0] idx);
    field_info_t info;
    info.tag   = TAG_NONE;
    info.limit = LIMIT_SHORT;
    if (rec == REC_P && idx == 8'd5) begin
      info.tag   = TAG_PATIENT;
      info.limit = LIMIT_PATIENT;
    end else if (rec == REC_O && idx == 8'd2) begin
      info.tag = TAG_SAMPLE;
    end else if (rec == REC_R) begin
      if (idx == 8'd2) begin
        info.tag = TAG_TEST;
      end else if (idx == 8'd3) begin
        info.tag = TAG_VALUE;
      end else if (idx == 8'd4) begin
        info.tag = TAG_UNIT;
      end else if (idx == 8'd12) begin
        info.tag   = TAG_DATE;
        info.limit = LIMIT_DATE;
      end
    end
    return info;
  endfunction

endpackage

// ===== rtl/astm_rfe_in_reg.sv =====
// ----------------------------------------------------------------------------
// astm_rfe_in_reg
// Input register: holds one received byte until the parser consumes it
// ----------------------------------------------------------------------------
module astm_rfe_in_reg
  import astm_rfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       out_busy_i,
  output logic       go_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  // byte moves on whenever the result side can take a result
  assign go_o       = valid_q && !out_busy_i;
  assign in_stall_o = valid_q && out_busy_i;
  assign byte_o     = byte_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // byte capture on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= rx_byte_i;
    end
  end

endmodule

// ===== rtl/astm_rfe_parser.sv =====
// ----------------------------------------------------------------------------
// astm_rfe_parser
// Frame and record tracking; the result of each byte is decided combinationally in its go cycle
// ----------------------------------------------------------------------------
module astm_rfe_parser
  import astm_rfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       go_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic        frame_q, frame_d;
  record_e     rec_q, rec_d;
  expect_e     exp_q, exp_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  chars_q, chars_d;
  logic [7:0]  type_q, type_d;
  field_info_t info;
  logic        type_hit;
  logic [7:0]  ch;

  assign info = tag_of(rec_q, idx_q);
  assign ch   = (byte_i == CH_CARET) ? CH_SPACE : byte_i;

  // next state and result
  always_comb begin
    frame_d     = frame_q;
    rec_d       = rec_q;
    exp_d       = exp_q;
    idx_d       = idx_q;
    chars_d     = chars_q;
    type_d      = type_q;
    type_hit    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (go_i) begin
      if (byte_i == CH_STX) begin
        idx_d   = '0;
        chars_d = '0;
        frame_d = 1'b1;
      end else if (frame_q) begin
        if (byte_i == CH_BAR || byte_i == CH_CR) begin
          // field end
          idx_d   = (idx_q != FIELD_MAX) ? idx_q + 8'd1 : idx_q;
          chars_d = '0;
          if (idx_q == 8'd0 && chars_q >= 8'd2) begin
            if (type_q == CH_TYPE_H) begin
              type_hit = 1'b1;
              rec_d    = REC_H;
              exp_d    = EXP_P;
            end else if (type_q == CH_TYPE_P && exp_q == EXP_P) begin
              type_hit = 1'b1;
              rec_d    = REC_P;
              exp_d    = EXP_O;
            end else if (type_q == CH_TYPE_O && exp_q == EXP_O) begin
              type_hit = 1'b1;
              rec_d    = REC_O;
              exp_d    = EXP_R;
            end else if (type_q == CH_TYPE_R && exp_q == EXP_R) begin
              type_hit = 1'b1;
              rec_d    = REC_R;
              exp_d    = EXP_H;
            end else if (type_q == CH_TYPE_L && exp_q == EXP_L) begin
              type_hit = 1'b1;
              rec_d    = REC_L;
              exp_d    = EXP_H;
            end
          end
          if (!type_hit) begin
            case (rec_q)
              REC_H, REC_L: begin
              end
              REC_P, REC_O, REC_R: begin
                if (info.tag != TAG_NONE) begin
                  res_valid_o       = 1'b1;
                  res_o.event_res   = 1'b1;
                  res_o.field_tag   = info.tag;
                  res_o.char_code   = '0;
                  res_o.record_done = (info.tag == TAG_DATE);
                end
              end
              default: begin
                // unknown record: drop the frame until the next start byte
                frame_d = 1'b0;
                rec_d   = REC_NONE;
                exp_d   = EXP_H;
                idx_d   = '0;
              end
            endcase
          end
        end else if (byte_i == CH_ETX) begin
          rec_d   = REC_NONE;
          frame_d = 1'b0;
        end else begin
          // field character
          if (chars_q == 8'd1) begin
            type_d = ch;
          end
          if (info.tag != TAG_NONE && chars_q < info.limit) begin
            res_valid_o       = 1'b1;
            res_o.event_res   = 1'b0;
            res_o.field_tag   = info.tag;
            res_o.char_code   = ch;
            res_o.record_done = 1'b0;
          end
          if (chars_q != FIELD_MAX) begin
            chars_d = chars_q + 8'd1;
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 1'b0;
      rec_q   <= REC_NONE;
      exp_q   <= EXP_H;
      idx_q   <= '0;
      chars_q <= '0;
      type_q  <= '0;
    end else begin
      frame_q <= frame_d;
      rec_q   <= rec_d;
      exp_q   <= exp_d;
      idx_q   <= idx_d;
      chars_q <= chars_d;
      type_q  <= type_d;
    end
  end

endmodule

// ===== rtl/astm_rfe_out_reg.sv =====
// ----------------------------------------------------------------------------
// astm_rfe_out_reg
// Result register: holds one result until the receiver takes it
// ----------------------------------------------------------------------------
module astm_rfe_out_reg
  import astm_rfe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t res_o,
  output logic    busy_o
);

  logic    valid_q;
  result_t res_q;

  assign busy_o      = valid_q && out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!busy_o) begin
      valid_q <= res_valid_i;
    end
  end

  // payload load
  always_ff @(posedge clk_i) begin
    if (!busy_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== rtl/astm_record_field_extractor_top.sv =====
// ----------------------------------------------------------------------------
// astm_record_field_extractor_top
// Streams selected fields out of an ASTM style laboratory byte stream
// ----------------------------------------------------------------------------
// Input channel: one received byte per transaction on rx_byte_i, handshake
// in_valid_i / in_stall_o. Output channel: zero or one result per byte on
// event_res_o, field_tag_o, char_code_o, record_done_o, handshake
// out_valid_o / out_stall_i. A transaction completes at a clock edge with
// valid high and stall low.
// Path: an accepted byte passes the input register, then the parser logic
// into the result register, which shows its result on the outputs.
// Throughput: one byte per cycle while no result is held by out_stall_i;
// the parser state updates once per byte.
// Reset: all control state clears, the block waits for STX and expects a header
// record; both registers come up empty.
// Stall: while a result is held by out_stall_i, the parser stops and the
// input register keeps its byte; in_stall_o rises only once that register
// is full, so one more byte is still taken.
// ----------------------------------------------------------------------------
module astm_record_field_extractor_top
  import astm_rfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_res_o,
  output logic [2:0] field_tag_o,
  output logic [7:0] char_code_o,
  output logic       record_done_o
);

  logic       out_busy;
  logic       go;
  logic [7:0] byte_q;
  logic       res_valid;
  result_t    res;
  result_t    res_out;

  // input register
  astm_rfe_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_busy_i (out_busy),
    .go_o       (go),
    .byte_o     (byte_q)
  );

  // parser
  astm_rfe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .byte_i      (byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  astm_rfe_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res_out),
    .busy_o      (out_busy)
  );

  assign event_res_o   = res_out.event_res;
  assign field_tag_o   = res_out.field_tag;
  assign char_code_o   = res_out.char_code;
  assign record_done_o = res_out.record_done;

endmodule

// ===== rtl/astm_rfe_checker.sv =====
// ----------------------------------------------------------------------------
// astm_rfe_checker
// Port level checks of the record field extractor, bound to the top level
// ----------------------------------------------------------------------------
`include "astm_record_field_extractor_top_assert.svh"

module astm_rfe_checker
  import astm_rfe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       event_res_o,
  input logic [2:0] field_tag_o,
  input logic [7:0] char_code_o,
  input logic       record_done_o
);

  // a stalled result stays offered
  `ASTM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped")

  // a stalled result keeps its payload
  `ASTM_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(event_res_o) && $stable(field_tag_o) && $stable(char_code_o) && $stable(record_done_o), "payload changed")

  // record done only on the date field end
  `ASTM_ASSERT_SAME(a_done_date, out_valid_o && record_done_o, event_res_o && field_tag_o == TAG_DATE, "bad record done")

  // field end carries a zero character and a tracked tag
  `ASTM_ASSERT_SAME(a_end_zero, out_valid_o && event_res_o, char_code_o == 8'd0 && field_tag_o <= TAG_DATE, "bad field end")

  // input stalls only while a result is held back
  `ASTM_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without cause")

endmodule

bind astm_record_field_extractor_top astm_rfe_checker u_checker (.*);
